[rtl/tsb_pkg.sv]
// Shared types, sizes and codes for the per-channel timestamp sort buffer.
// No dependencies; every rtl file imports this package.
package tsb_pkg;

  localparam int NUM_SYSTEMS = 16;
  // Queue depth is a power of two so that ring indexes wrap by truncation.
  localparam int QUEUE_DEPTH = 256;
  localparam int TIME_BITS   = 48;
  localparam int PAY_BITS    = 32;

  localparam int SYS_W  = (NUM_SYSTEMS > 1) ? $clog2(NUM_SYSTEMS) : 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = SYS_W + IDX_W;
  localparam int TOT_W  = $clog2(NUM_SYSTEMS * QUEUE_DEPTH + 1);
  localparam int SWP_W  = SYS_W + 1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_NOT_DUE = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  typedef struct packed {
    logic [TIME_BITS-1:0] etime;
    logic [PAY_BITS-1:0]  payload;
  } entry_t;

endpackage

[rtl/tsb_store.sv]
// Entry store: one ring of QUEUE_DEPTH entries per system, one write and
// one registered read per cycle. Depends on tsb_pkg.
module tsb_store (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [tsb_pkg::ADDR_W-1:0] waddr_i,
  input  tsb_pkg::entry_t       wdata_i,
  input  logic [tsb_pkg::ADDR_W-1:0] raddr_i,
  output tsb_pkg::entry_t       rdata_o
);
  import tsb_pkg::*;

  entry_t mem_q [NUM_SYSTEMS*QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/per_channel_timestamp_sort_buffer.sv]
// Top level of the per-channel timestamp sort buffer: sequencer, per-system
// ring pointers and counts, and the summary sweep. Depends on tsb_pkg, tsb_store.
//
// Usage: raise start with func_i and its operands while busy is low; the
// request is taken on that edge and busy stays high until the result is out.
// An insert places (item_time_i, item_payload_i) in system_id_i's queue in
// time order, after any entries of equal time; a pop removes the head when
// the queue holds one and, with use_limit_i set, its time is below limit_time_i.
// Each request gives exactly one result, shown for one cycle with valid_o;
// the receiver cannot stall, so results must be taken when shown.
// Flow: the store has one write port and one registered read port. An insert
// into a non-empty queue walks back from the tail, moving each held entry
// later than the new one up by one slot, then writes the new entry; an insert
// into an empty queue writes it at once. Every request, also an illegal id, a
// full queue or an empty pop, ends with the summary sweep, which reads the head
// and tail of every system through the read port, folding heads into the
// earliest time and tails into the latest time.
// The next request can be taken the cycle after valid_o.
// Reset clears all counts and ring pointers, so every queue starts empty;
// the entry store itself is not cleared.
module per_channel_timestamp_sort_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [7:0]  system_id_i,
  input  logic [47:0] item_time_i,
  input  logic [31:0] item_payload_i,
  input  logic        use_limit_i,
  input  logic [47:0] limit_time_i,
  output logic        valid_o,
  output logic [2:0]  status_o,
  output logic        popped_o,
  output logic [47:0] out_time_o,
  output logic [31:0] out_payload_o,
  output logic [8:0]  channel_count_o,
  output logic [12:0] total_count_o,
  output logic        any_data_o,
  output logic [47:0] earliest_time_o,
  output logic [47:0] latest_time_o
);
  import tsb_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHECK   = 3'd1;
  localparam logic [2:0] S_INS_RD  = 3'd2;
  localparam logic [2:0] S_INS_CMP = 3'd3;
  localparam logic [2:0] S_INS_PUT = 3'd4;
  localparam logic [2:0] S_POP_CMP = 3'd5;
  localparam logic [2:0] S_SUM     = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  localparam logic [SWP_W-1:0] SWP_LAST = SWP_W'(2 * NUM_SYSTEMS - 1);

  logic [2:0] state_q, state_d;

  logic [CNT_W-1:0] cnt_q  [NUM_SYSTEMS];
  logic [IDX_W-1:0] head_q [NUM_SYSTEMS];

  // latched request
  logic                 func_q;
  logic [7:0]           sys_q;
  logic [TIME_BITS-1:0] itime_q;
  logic [PAY_BITS-1:0]  ipay_q;
  logic                 uselim_q;
  logic [TIME_BITS-1:0] lim_q;

  logic [CNT_W-1:0] pos_q;
  logic [SWP_W-1:0] swp_q;
  logic             tag_valid_q, tag_tail_q, tag_full_q;

  logic [2:0]           status_q;
  logic                 popped_q;
  logic [TIME_BITS-1:0] otime_q;
  logic [PAY_BITS-1:0]  opay_q;
  logic [CNT_W-1:0]     chan_q;
  logic [TOT_W-1:0]     total_q;
  logic [TIME_BITS-1:0] first_q, last_q;

  logic             sys_ok;
  logic [SYS_W-1:0] cur_sys;
  logic [CNT_W-1:0] cur_cnt;
  logic [IDX_W-1:0] cur_head;
  logic [IDX_W-1:0] rd_idx;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wdata, rdata;

  assign sys_ok   = (sys_q < 8'(NUM_SYSTEMS));
  assign cur_sys  = (state_q == S_SUM) ? swp_q[SWP_W-1:1] : sys_q[SYS_W-1:0];
  assign cur_cnt  = cnt_q[cur_sys];
  assign cur_head = head_q[cur_sys];

  // read address: ring slot relative to the head of the current system
  always_comb begin
    rd_idx = '0;
    case (state_q)
      S_CHECK:  rd_idx = (func_q == FUNC_INSERT) ? IDX_W'(cur_cnt - 1'b1) : '0;
      S_INS_RD: rd_idx = IDX_W'(pos_q - 1'b1);
      S_SUM:    rd_idx = swp_q[0] ? IDX_W'(cur_cnt - 1'b1) : '0;
      default:  rd_idx = '0;
    endcase
  end
  assign raddr = {cur_sys, IDX_W'(cur_head + rd_idx)};

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    waddr = {cur_sys, IDX_W'(cur_head + IDX_W'(pos_q))};
    if (state_q == S_INS_CMP && rdata.etime > itime_q) begin
      we = 1'b1;
    end else if (state_q == S_INS_PUT) begin
      we            = 1'b1;
      wdata.etime   = itime_q;
      wdata.payload = ipay_q;
    end
  end

  tsb_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start) state_d = S_CHECK;
      S_CHECK: begin
        if (!sys_ok) begin
          state_d = S_SUM;
        end else if (func_q == FUNC_INSERT) begin
          if (cur_cnt >= CNT_W'(QUEUE_DEPTH)) state_d = S_SUM;
          else if (cur_cnt == '0)             state_d = S_INS_PUT;
          else                                state_d = S_INS_CMP;
        end else begin
          state_d = (cur_cnt == '0) ? S_SUM : S_POP_CMP;
        end
      end
      S_INS_RD:  state_d = S_INS_CMP;
      S_INS_CMP: begin
        if (rdata.etime > itime_q && pos_q != CNT_W'(1)) state_d = S_INS_RD;
        else                                              state_d = S_INS_PUT;
      end
      S_INS_PUT: state_d = S_SUM;
      S_POP_CMP: state_d = S_SUM;
      // stay in the sweep after the last issue so the last tail read is folded
      S_SUM:     if (swp_q == SWP_LAST && tag_valid_q && tag_tail_q) state_d = S_OUT;
      S_OUT:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tag_valid_q <= 1'b0;
      swp_q       <= '0;
      for (int s = 0; s < NUM_SYSTEMS; s++) begin
        cnt_q[s]  <= '0;
        head_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CHECK: begin
          swp_q       <= '0;
          tag_valid_q <= 1'b0;
        end
        S_INS_PUT: cnt_q[cur_sys] <= cur_cnt + 1'b1;
        S_POP_CMP: begin
          if (!(uselim_q && !(rdata.etime < lim_q))) begin
            cnt_q[cur_sys]  <= cur_cnt - 1'b1;
            head_q[cur_sys] <= cur_head + 1'b1;
          end
        end
        S_SUM: begin
          tag_valid_q <= 1'b1;
          if (swp_q != SWP_LAST) swp_q <= swp_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_q   <= func_i;
          sys_q    <= system_id_i;
          itime_q  <= item_time_i;
          ipay_q   <= item_payload_i;
          uselim_q <= use_limit_i;
          lim_q    <= limit_time_i;
        end
      end
      S_CHECK: begin
        popped_q <= 1'b0;
        otime_q  <= '0;
        opay_q   <= '0;
        total_q  <= '0;
        first_q  <= '1;
        last_q   <= '0;
        pos_q    <= cur_cnt;
        chan_q   <= sys_ok ? cur_cnt : '0;
        if (!sys_ok)                                  status_q <= ST_ILLEGAL;
        else if (func_q == FUNC_INSERT)
          status_q <= (cur_cnt >= CNT_W'(QUEUE_DEPTH)) ? ST_FULL : ST_OK;
        else
          status_q <= (cur_cnt == '0) ? ST_EMPTY : ST_OK;
      end
      S_INS_CMP: if (rdata.etime > itime_q) pos_q <= pos_q - 1'b1;
      S_INS_PUT: chan_q <= chan_q + 1'b1;
      S_POP_CMP: begin
        if (uselim_q && !(rdata.etime < lim_q)) begin
          status_q <= ST_NOT_DUE;
        end else begin
          popped_q <= 1'b1;
          otime_q  <= rdata.etime;
          opay_q   <= rdata.payload;
          chan_q   <= chan_q - 1'b1;
        end
      end
      S_SUM: begin
        // issue side: add the count once per system, tag the read in flight
        tag_tail_q <= swp_q[0];
        tag_full_q <= (cur_cnt != '0);
        if (!swp_q[0]) total_q <= total_q + TOT_W'(cur_cnt);
        // fold side: head reads feed the minimum, tail reads the maximum
        if (tag_valid_q && tag_full_q) begin
          if (!tag_tail_q && rdata.etime < first_q) first_q <= rdata.etime;
          if (tag_tail_q && rdata.etime > last_q)   last_q  <= rdata.etime;
        end
      end
      default: ;
    endcase
  end

  assign busy            = (state_q != S_IDLE);
  assign valid_o         = (state_q == S_OUT);
  assign status_o        = status_q;
  assign popped_o        = popped_q;
  assign out_time_o      = otime_q;
  assign out_payload_o   = opay_q;
  assign channel_count_o = chan_q;
  assign total_count_o   = total_q;
  assign any_data_o      = (total_q != '0);
  assign earliest_time_o = (total_q != '0) ? first_q : '0;
  assign latest_time_o   = last_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy) else $error("result strobe longer than one cycle");
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && popped_o) |-> (status_o == ST_OK && func_q == FUNC_POP))
    else $error("popped flag without a successful pop");
  a_any_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && any_data_o) |-> (earliest_time_o <= latest_time_o))
    else $error("earliest time beyond latest time");

endmodule

[dv/per_channel_timestamp_sort_buffer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for per_channel_timestamp_sort_buffer: random and
// directed inserts and pops checked against a queue model kept in the bench.
// Depends on tsb_pkg and the block's RTL.
module per_channel_timestamp_sort_buffer_test;
  import tsb_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic        popped;
    logic [47:0] out_time;
    logic [31:0] out_payload;
    logic [8:0]  channel_count;
    logic [12:0] total_count;
    logic        any_data;
    logic [47:0] earliest_time;
    logic [47:0] latest_time;
  } outcome_t;

  class sort_scoreboard;
    logic [47:0] times [NUM_SYSTEMS][$];
    logic [31:0] pays [NUM_SYSTEMS][$];
    outcome_t    pending [$];
    int          mismatches;
    int          checked;

    // Compute the outcome of one accepted request and queue it.
    function void note_request(logic func, logic [7:0] sys, logic [47:0] t,
                               logic [31:0] pay, logic lim_en, logic [47:0] lim);
      outcome_t o;
      int pos;
      int total;
      bit any;
      o = '{default: '0};
      if (sys >= NUM_SYSTEMS) begin
        o.status = ST_ILLEGAL;
      end else if (func == FUNC_INSERT) begin
        if (times[sys].size() >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          // Equal times go after the entries already held.
          pos = times[sys].size();
          while (pos > 0 && times[sys][pos-1] > t) pos--;
          times[sys].insert(pos, t);
          pays[sys].insert(pos, pay);
        end
      end else if (times[sys].size() == 0) begin
        o.status = ST_EMPTY;
      end else if (lim_en && !(times[sys][0] < lim)) begin
        o.status = ST_NOT_DUE;
      end else begin
        o.popped = 1'b1;
        o.out_time = times[sys].pop_front();
        o.out_payload = pays[sys].pop_front();
      end
      if (sys < NUM_SYSTEMS) o.channel_count = 9'(times[sys].size());
      total = 0;
      any = 0;
      for (int s = 0; s < NUM_SYSTEMS; s++) begin
        if (times[s].size() == 0) continue;
        total += times[s].size();
        if (!any || times[s][0] < o.earliest_time) o.earliest_time = times[s][0];
        if (!any || times[s][$] > o.latest_time) o.latest_time = times[s][$];
        any = 1;
      end
      o.total_count = 13'(total);
      o.any_data = any;
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t w;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, status %0d", got.status);
        return;
      end
      w = pending.pop_front();
      if (got !== w) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp st=%0d pop=%0b t=%h p=%h ch=%0d tot=%0d any=%0b e=%h l=%h",
                   checked, w.status, w.popped, w.out_time, w.out_payload, w.channel_count,
                   w.total_count, w.any_data, w.earliest_time, w.latest_time);
        if (mismatches <= 10)
          $display("             got st=%0d pop=%0b t=%h p=%h ch=%0d tot=%0d any=%0b e=%h l=%h",
                   got.status, got.popped, got.out_time, got.out_payload, got.channel_count,
                   got.total_count, got.any_data, got.earliest_time, got.latest_time);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;

  logic        clk_i, rst_ni, start, busy;
  logic        func_i, use_limit_i;
  logic [7:0]  system_id_i;
  logic [47:0] item_time_i, limit_time_i;
  logic [31:0] item_payload_i;
  logic        valid_o, popped_o, any_data_o;
  logic [2:0]  status_o;
  logic [47:0] out_time_o, earliest_time_o, latest_time_o;
  logic [31:0] out_payload_o;
  logic [8:0]  channel_count_o;
  logic [12:0] total_count_o;

  sort_scoreboard board;
  int  idle_cycles;
  int  requests_sent;
  int  full_hits, due_hits, pops_done;
  bit  allow_gaps;

  per_channel_timestamp_sort_buffer DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which neither side moves anything.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL per_channel_timestamp_sort_buffer");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (status_o == ST_FULL) full_hits++;
      if (status_o == ST_NOT_DUE) due_hits++;
      if (popped_o) pops_done++;
      board.check_result('{status_o, popped_o, out_time_o, out_payload_o, channel_count_o,
                           total_count_o, any_data_o, earliest_time_o, latest_time_o});
    end
  end

  task automatic send_request(logic func, logic [7:0] sys, logic [47:0] t,
                              logic [31:0] pay, logic lim_en, logic [47:0] lim);
    int gap;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= func;
    system_id_i <= sys;
    item_time_i <= t;
    item_payload_i <= pay;
    use_limit_i <= lim_en;
    limit_time_i <= lim;
    do @(posedge clk_i); while (busy);
    board.note_request(func, sys, t, pay, lim_en, lim);
    requests_sent++;
    start <= 1'b0;
    // the block stays busy after the accept anyway; step past this edge
    @(posedge clk_i);
  endtask

  task automatic drain;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [47:0] rand_time(int mode);
    case (mode)
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(0, 40));
      default: return 48'(32'h1000 + $urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    logic [7:0]  sys;
    logic [47:0] t;
    int          mode;
    board = new();
    idle_cycles = 0;
    requests_sent = 0;
    full_hits = 0;
    due_hits = 0;
    pops_done = 0;
    allow_gaps = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FUNC_INSERT;
    system_id_i = '0;
    item_time_i = '0;
    item_payload_i = '0;
    use_limit_i = 1'b0;
    limit_time_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops, illegal ids, extreme times, ties, limits.
    send_request(FUNC_POP, 8'd0, '0, '0, 1'b0, '0);
    send_request(FUNC_INSERT, 8'd16, 48'h5, 32'h1, 1'b0, '0);
    send_request(FUNC_POP, 8'hFF, '0, '0, 1'b1, '1);
    send_request(FUNC_INSERT, 8'd15, '1, 32'hFFFF_FFFF, 1'b0, '0);
    send_request(FUNC_INSERT, 8'd15, '0, 32'h0, 1'b1, '1);
    send_request(FUNC_INSERT, 8'd15, 48'h10, 32'hA, 1'b0, '0);
    send_request(FUNC_INSERT, 8'd15, 48'h10, 32'hB, 1'b0, '0);
    send_request(FUNC_INSERT, 8'd3, 48'h8, 32'hC, 1'b0, '0);
    send_request(FUNC_POP, 8'd15, '0, '0, 1'b1, 48'h0);
    send_request(FUNC_POP, 8'd15, '0, '0, 1'b1, 48'h1);
    send_request(FUNC_POP, 8'd15, '0, '0, 1'b1, 48'h10);
    send_request(FUNC_POP, 8'd15, '0, '0, 1'b0, '0);
    send_request(FUNC_POP, 8'd15, '0, '0, 1'b0, '0);
    send_request(FUNC_POP, 8'd15, '0, '0, 1'b1, '1);
    send_request(FUNC_POP, 8'd3, '1, '1, 1'b0, '1);
    send_request(FUNC_POP, 8'd3, '0, '0, 1'b0, '0);
    // Hold off until everything is back.
    drain();

    // Fill system 7 to the brim with mostly ascending times, then overflow.
    for (int i = 0; i < QUEUE_DEPTH + 3; i++) begin
      t = (i % 16 == 0) ? rand_time(1) : 48'(1000 + i);
      send_request(FUNC_INSERT, 8'd7, t, $urandom, 1'b0, '0);
    end

    // Random mix; no gaps in the last stretch.
    for (int i = 0; i < 330; i++) begin
      if (i > 280) allow_gaps = 1'b0;
      if ($urandom_range(0, 19) == 0) sys = 8'($urandom_range(16, 255));
      else sys = 8'($urandom_range(0, NUM_SYSTEMS - 1));
      mode = $urandom_range(0, 2);
      t = rand_time(mode);
      if ($urandom_range(0, 9) < 5)
        send_request(FUNC_INSERT, sys, t, $urandom, 1'($urandom_range(0, 1)), rand_time(0));
      else
        send_request(FUNC_POP, sys, rand_time(0), $urandom, 1'($urandom_range(0, 1)),
                     (mode == 0) ? rand_time(0) : rand_time(1));
      if (i == 150) drain();
    end

    drain();
    repeat (600) @(posedge clk_i);
    $display("Sent %0d requests: %0d pops returned data, %0d full drops, %0d not-due holds.",
             requests_sent, pops_done, full_hits, due_hits);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("PASS per_channel_timestamp_sort_buffer");
    else
      $display("FAIL per_channel_timestamp_sort_buffer");
    $finish;
  end
endmodule

[filelist.f]
rtl/tsb_pkg.sv
rtl/tsb_store.sv
rtl/per_channel_timestamp_sort_buffer.sv
dv/per_channel_timestamp_sort_buffer_test.sv
